// ===== hdl/line_prefix_dispatcher_unit_macros.svh =====
// Assertion macros for the line prefix dispatcher.
// LPD_ASSERT_IMP checks a same-cycle implication, LPD_ASSERT_NXT a next-cycle one.
// Both sample on clk and are disabled while rst_n is low.
`ifndef LINE_PREFIX_DISPATCHER_UNIT_MACROS_SVH
`define LINE_PREFIX_DISPATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpd: same-cycle check failed");
`define LPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpd: next-cycle check failed");
`else
`define LPD_ASSERT_IMP(label, ante, cons)
`define LPD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

  // Field widths of the request and result channels
  localparam int MODE_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int SLOT_FLD_W = 3;
  localparam int POS_W      = 5;
  localparam int PLEN_W     = 5;
  localparam int MASK_W     = 8;
  localparam int LINE_LEN_W = 11;

  // Line terminators
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // Request kinds; the fourth code is unused and ignored
  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE   = 2'd0,
    MODE_PREFIX = 2'd1,
    MODE_LENGTH = 2'd2
  } mode_t;

  typedef logic [MASK_W-1:0]     mask_t;
  typedef logic [LINE_LEN_W-1:0] line_len_t;

  // Prefix byte write into the prefix memory
  typedef struct packed {
    logic                  en;
    logic [POS_W-1:0]      pos;
    logic [SLOT_FLD_W-1:0] slot;
    logic [BYTE_W-1:0]     data;
  } pfx_wr_t;

endpackage

// ===== hdl/lpd_in_if.sv =====
interface lpd_in_if;
  logic                             valid;
  logic                             ready;
  logic [lpd_pkg::MODE_W-1:0]       mode;
  logic [lpd_pkg::BYTE_W-1:0]       data_byte;
  logic [lpd_pkg::SLOT_FLD_W-1:0]   slot;
  logic [lpd_pkg::POS_W-1:0]        position;
  logic [lpd_pkg::PLEN_W-1:0]       prefix_length;
  logic                             enable;

  modport source (
    output valid, mode, data_byte, slot, position, prefix_length, enable,
    input  ready
  );
  modport sink (
    input  valid, mode, data_byte, slot, position, prefix_length, enable,
    output ready
  );
endinterface

// ===== hdl/lpd_out_if.sv =====
interface lpd_out_if;
  logic                           valid;
  logic                           ready;
  logic [lpd_pkg::MASK_W-1:0]     match_mask;
  logic [lpd_pkg::LINE_LEN_W-1:0] line_length;

  modport source (
    output valid, match_mask, line_length,
    input  ready
  );
  modport sink (
    input  valid, match_mask, line_length,
    output ready
  );
endinterface

// ===== hdl/lpd_prefix_mem.sv =====
module lpd_prefix_mem #(
  parameter int SLOTS  = 8,
  parameter int DEPTH  = 23,
  parameter int SLOT_W = 3,
  parameter int AW     = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpd_pkg::pfx_wr_t      wr,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [SLOTS*8-1:0]    rd_data
);

  logic [SLOTS*8-1:0] prefix_mem [DEPTH];
  logic [SLOTS-1:0]   lane_vld_r [DEPTH];
  logic [SLOTS*8-1:0] rd_raw_r;
  logic [SLOTS-1:0]   rd_vld_r;
  logic [AW-1:0]      wr_addr;
  logic [SLOT_W-1:0]  wr_lane;

  assign wr_addr = AW'(wr.pos);
  assign wr_lane = SLOT_W'(wr.slot);

  // Byte-lane write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      prefix_mem[wr_addr][int'(wr_lane) * 8 +: 8] <= wr.data;
    end
    if (rd_en) begin
      rd_raw_r <= prefix_mem[rd_addr];
    end
  end

  // Track written lanes; an unwritten lane reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        lane_vld_r[i] <= '0;
      end
      rd_vld_r <= '0;
    end else begin
      if (wr.en) begin
        lane_vld_r[wr_addr][wr_lane] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= lane_vld_r[rd_addr];
      end
    end
  end

  // Mask lanes never written
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      rd_data[s*8 +: 8] = rd_vld_r[s] ? rd_raw_r[s*8 +: 8] : 8'h00;
    end
  end

endmodule

// ===== hdl/line_prefix_dispatcher_unit.sv =====
// Line prefix dispatcher: takes one request per cycle, either a received byte,
// a prefix byte write or a slot length/enable write, and splits the byte stream
// into lines at CR or LF. Each completed line that is non-empty, did not reach
// the line buffer limit and does not start with a zero byte yields one result:
// the mask of enabled slots whose whole prefix matched, plus the line length.
// Prefix bytes sit in a registered-read memory read at the current line
// position when a byte is accepted; the compare happens in the following cycle,
// and a result passes from the compare stage into the output register after
// its terminator is accepted. Requests are taken every cycle; the input stalls
// only while a finished result waits in a full output register and another
// result is ready behind it. No clearing pass is needed after reset.
`include "line_prefix_dispatcher_unit_macros.svh"

module line_prefix_dispatcher_unit #(
  parameter int SLOTS        = 8,
  parameter int PREFIX_BYTES = 23,
  parameter int LINE_BUFFER  = 2048
) (
  input logic       clk,
  input logic       rst_n,
  lpd_in_if.sink    in_chan,
  lpd_out_if.source out_chan
);

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW      = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam int LW      = $clog2(PREFIX_BYTES + 1);
  localparam int CLW     = $clog2(LINE_BUFFER);
  localparam int LEN_MAX = LINE_BUFFER - 1;

  // Request decode
  logic in_accept;
  logic is_byte;
  logic is_term;
  logic slot_ok;
  logic pos_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic [LW-1:0]     plen_sat;

  // Slot configuration
  logic [LW-1:0]    slot_len_r [SLOTS];
  logic [SLOTS-1:0] slot_en_r;

  // Line state
  logic [CLW-1:0] len_r, len_nxt;
  logic           ovf_r, ovf_nxt;
  logic           fbz_r, fbz_nxt;
  logic [SLOTS-1:0] still_r, still_nxt;

  // Entry to the compare stage
  logic             rd_en;
  logic             cmp_in;
  logic             term_in;
  logic             res_in;
  logic [SLOTS-1:0] sel_in;

  // Compare stage
  logic             s1_v_r;
  logic             s1_cmp_r;
  logic             s1_term_r;
  logic             s1_res_r;
  logic [7:0]       s1_byte_r;
  logic [SLOTS-1:0] s1_sel_r;
  logic [CLW-1:0]   s1_len_r;
  logic             s1_stall;
  logic [SLOTS*8-1:0] rd_data;

  // Output register
  logic               out_valid_r;
  lpd_pkg::mask_t     out_mask_r;
  lpd_pkg::line_len_t out_len_r;

  lpd_pkg::pfx_wr_t pfx_wr;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign is_byte   = in_chan.mode == lpd_pkg::MODE_BYTE;
  assign is_term   = is_byte && (in_chan.data_byte == lpd_pkg::CH_CR ||
                                 in_chan.data_byte == lpd_pkg::CH_LF);
  assign slot_ok   = 32'(in_chan.slot) < SLOTS;
  assign pos_ok    = 32'(in_chan.position) < PREFIX_BYTES;
  assign slot_idx  = SLOT_W'(in_chan.slot);
  assign plen_sat  = (32'(in_chan.prefix_length) > PREFIX_BYTES) ?
                     LW'(PREFIX_BYTES) : LW'(in_chan.prefix_length);

  // Prefix byte write request
  always_comb begin
    pfx_wr.en   = in_accept && in_chan.mode == lpd_pkg::MODE_PREFIX && slot_ok && pos_ok;
    pfx_wr.pos  = in_chan.position;
    pfx_wr.slot = in_chan.slot;
    pfx_wr.data = in_chan.data_byte;
  end

  lpd_prefix_mem #(
    .SLOTS  (SLOTS),
    .DEPTH  (PREFIX_BYTES),
    .SLOT_W (SLOT_W),
    .AW     (AW)
  ) u_prefix_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pfx_wr),
    .rd_en   (rd_en),
    .rd_addr (AW'(len_r)),
    .rd_data (rd_data)
  );

  // Update slot length and enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_len_r[s] <= '0;
      end
      slot_en_r <= '0;
    end else if (in_accept && in_chan.mode == lpd_pkg::MODE_LENGTH && slot_ok) begin
      slot_len_r[slot_idx] <= plen_sat;
      slot_en_r[slot_idx]  <= in_chan.enable;
    end
  end

  // Advance length, overflow and first-byte state; issue the prefix read
  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    fbz_nxt = fbz_r;
    rd_en   = 1'b0;
    cmp_in  = 1'b0;
    term_in = 1'b0;
    res_in  = 1'b0;
    sel_in  = '0;
    if (in_accept && is_byte) begin
      if (is_term) begin
        term_in = 1'b1;
        res_in  = !ovf_r && len_r != '0 && !fbz_r;
        for (int s = 0; s < SLOTS; s++) begin
          sel_in[s] = slot_en_r[s] && 32'(len_r) >= 32'(slot_len_r[s]);
        end
        len_nxt = '0;
        ovf_nxt = 1'b0;
        fbz_nxt = 1'b0;
      end else if (!ovf_r) begin
        if (len_r == CLW'(LEN_MAX)) begin
          len_nxt = '0;
          ovf_nxt = 1'b1;
        end else begin
          if (len_r == '0 && in_chan.data_byte == 8'h00) begin
            fbz_nxt = 1'b1;
          end
          if (32'(len_r) < PREFIX_BYTES) begin
            rd_en  = 1'b1;
            cmp_in = 1'b1;
            for (int s = 0; s < SLOTS; s++) begin
              sel_in[s] = 32'(len_r) < 32'(slot_len_r[s]);
            end
          end
          len_nxt = len_r + CLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      fbz_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      fbz_r <= fbz_nxt;
    end
  end

  // Hold the compare stage while its result cannot enter the output register
  assign s1_stall       = s1_v_r && s1_res_r && out_valid_r && !out_chan.ready;
  assign in_chan.ready  = !s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_stall || (in_accept && (cmp_in || term_in));
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmp_r  <= cmp_in;
      s1_term_r <= term_in;
      s1_res_r  <= res_in;
      s1_byte_r <= in_chan.data_byte;
      s1_sel_r  <= sel_in;
      s1_len_r  <= len_r;
    end
  end

  // Drop match bits on a differing byte; restore all at the terminator
  always_comb begin
    still_nxt = still_r;
    if (s1_v_r && !s1_stall) begin
      if (s1_term_r) begin
        still_nxt = '1;
      end else if (s1_cmp_r) begin
        for (int s = 0; s < SLOTS; s++) begin
          if (s1_sel_r[s] && rd_data[s*8 +: 8] != s1_byte_r) begin
            still_nxt[s] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      still_r <= '1;
    end else begin
      still_r <= still_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_v_r && s1_res_r && !s1_stall) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_res_r && !s1_stall) begin
      out_mask_r <= lpd_pkg::mask_t'(s1_sel_r & still_r);
      out_len_r  <= lpd_pkg::line_len_t'(s1_len_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.match_mask  = out_mask_r;
  assign out_chan.line_length = out_len_r;

  `LPD_ASSERT_IMP(a_ready_low_only_when_full, !in_chan.ready, out_valid_r && !out_chan.ready)
  `LPD_ASSERT_NXT(a_stalled_result_kept, s1_stall, s1_v_r && s1_res_r)
  `LPD_ASSERT_IMP(a_overflow_len_cleared, ovf_r, len_r == '0)
  `LPD_ASSERT_IMP(a_zero_first_in_line, fbz_r, len_r != '0 || ovf_r)
  `LPD_ASSERT_IMP(a_len_below_buffer, 1'b1, 32'(len_r) < LINE_BUFFER)

endmodule
